### rtl/core/yri_pkg.sv
`timescale 1ns / 1ps

package yri_pkg;

    localparam int STAMP_W    = 63;
    localparam int RATE_W     = 32;
    localparam int ANGLE_W    = 32;
    localparam int Q_W        = 32;
    localparam int DEADBAND_W = 31;
    localparam int FIXED_W    = 30;
    localparam int CFG_W      = 31;
    localparam int STEP_W     = 32;
    localparam int PROD_W     = 63;

    localparam int CORDIC_STEPS = 30;
    localparam int IDX_W        = $clog2(CORDIC_STEPS);
    localparam int XY_W         = 33;
    localparam int Z_W          = 34;

    localparam logic [STAMP_W-1:0]  ONE_SECOND_NS     = 63'd1000000000;
    localparam logic [FIXED_W-1:0]  MIN_FIXED_STEP_NS = 30'd100000;
    localparam logic [STEP_W-1:0]   STEP_LIMIT        = 32'h8000_0000;
    localparam logic [31:0]         ANGLE_PER_RATE_NS = 32'd2935890503;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;
    localparam logic signed [XY_W-1:0] ONE_Q30         = 33'sd1073741824;

    typedef enum logic [0:0] {
        REG_RATE_DEADBAND = 1'b0,
        REG_FIXED_STEP    = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        FE_IDLE,
        FE_STEP,
        FE_MUL,
        FE_LO,
        FE_HI,
        FE_ADD
    } fe_state_t;

    // item handed from the integrator into the first rotation cell
    typedef struct packed {
        logic                 valid;
        logic [ANGLE_W-1:0]   yaw;
    } front_t;

    typedef struct packed {
        logic                 valid;
        logic [XY_W-1:0]      x;
        logic [XY_W-1:0]      y;
        logic [Z_W-1:0]       z;
        logic [ANGLE_W-1:0]   yaw;
    } cell_t;

    // atan(2^-i), full turn = 2^33
    function automatic logic [30:0] atan_q(input logic [4:0] idx);
        logic [30:0] v;
        case (idx)
            5'd0:  v = 31'd1073741824;
            5'd1:  v = 31'd633866811;
            5'd2:  v = 31'd334917815;
            5'd3:  v = 31'd170009512;
            5'd4:  v = 31'd85334662;
            5'd5:  v = 31'd42708931;
            5'd6:  v = 31'd21359677;
            5'd7:  v = 31'd10680490;
            5'd8:  v = 31'd5340326;
            5'd9:  v = 31'd2670173;
            5'd10: v = 31'd1335088;
            5'd11: v = 31'd667544;
            5'd12: v = 31'd333772;
            5'd13: v = 31'd166886;
            5'd14: v = 31'd83443;
            5'd15: v = 31'd41722;
            5'd16: v = 31'd20861;
            5'd17: v = 31'd10430;
            5'd18: v = 31'd5215;
            5'd19: v = 31'd2608;
            5'd20: v = 31'd1304;
            5'd21: v = 31'd652;
            5'd22: v = 31'd326;
            5'd23: v = 31'd163;
            5'd24: v = 31'd81;
            5'd25: v = 31'd41;
            5'd26: v = 31'd20;
            5'd27: v = 31'd10;
            5'd28: v = 31'd5;
            5'd29: v = 31'd3;
            5'd30: v = 31'd1;
            5'd31: v = 31'd1;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/yaw_rate_integrator_quaternion.sv
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// input     in_valid / in_ready  stamp_ns, yaw_rate
// output    out_valid/out_ready  quat_z, quat_w, yaw_angle_out
// config    cfg_we               cfg_index, cfg_data (write only)
//
// An item is accepted only while the front end is idle: it finds the step,
// then runs product and two scale halves through one shared 32x32 multiplier
// before the yaw updates. The result passes one rotation cell per CORDIC
// step. Cells move together; a held output stalls the whole row.
// Reset clears yaw, previous stamp and both registers.

module yaw_rate_integrator_quaternion
    import yri_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [STAMP_W-1:0]   stamp_ns,
    input  logic signed [RATE_W-1:0] yaw_rate,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [Q_W-1:0]     quat_z,
    output logic signed [Q_W-1:0]     quat_w,
    output logic signed [ANGLE_W-1:0] yaw_angle_out,
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    front_t  front;
    cell_t   head;
    cell_t   chain [0:CORDIC_STEPS];
    logic    chain_adv;
    logic    out_valid_reg, out_valid_next;
    logic signed [Q_W-1:0]     quat_z_reg, quat_w_reg;
    logic signed [ANGLE_W-1:0] yaw_out_reg;

    function automatic logic signed [Q_W-1:0] clamp_q30(input logic [XY_W-1:0] v);
        logic signed [XY_W-1:0] s;
        logic signed [XY_W-1:0] r;
        s = $signed(v);
        if (s > ONE_Q30)
            r = ONE_Q30;
        else if (s < -ONE_Q30)
            r = -ONE_Q30;
        else
            r = s;
        return r[Q_W-1:0];
    endfunction

    yri_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .stamp_ns  (stamp_ns),
        .yaw_rate  (yaw_rate),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .chain_adv (chain_adv),
        .front     (front)
    );

    // half yaw: the signed yaw read with a full turn of 2^33
    always_comb
    begin
        head.valid = front.valid;
        head.x     = CORDIC_GAIN_Q30;
        head.y     = '0;
        head.z     = {{(Z_W-ANGLE_W){front.yaw[ANGLE_W-1]}}, front.yaw};
        head.yaw   = front.yaw;
    end

    assign chain[0] = head;

    // hold the row while its last item waits on a full output register
    assign chain_adv = !(chain[CORDIC_STEPS].valid && out_valid_reg && !out_ready);

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        yri_cordic_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (chain_adv),
            .idx   (5'(i)),
            .cin   (chain[i]),
            .cout  (chain[i+1])
        );
    end

    assign out_valid_next = chain[CORDIC_STEPS].valid || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (chain[CORDIC_STEPS].valid && chain_adv)
        begin
            quat_z_reg  <= clamp_q30(chain[CORDIC_STEPS].y);
            quat_w_reg  <= clamp_q30(chain[CORDIC_STEPS].x);
            yaw_out_reg <= $signed(chain[CORDIC_STEPS].yaw);
        end
    end

    assign out_valid     = out_valid_reg;
    assign quat_z        = quat_z_reg;
    assign quat_w        = quat_w_reg;
    assign yaw_angle_out = yaw_out_reg;

`ifndef SYNTHESIS
    a_row_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (chain[CORDIC_STEPS].valid && out_valid_reg && !out_ready)
        |=> (chain[CORDIC_STEPS].valid && $stable(chain[CORDIC_STEPS].yaw)))
        else $error("last cell moved while the output was blocked");

    a_item_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        (chain[CORDIC_STEPS].valid && chain_adv) |=> out_valid_reg)
        else $error("item left the row but never reached the output");

    a_quat_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (quat_z_reg <= 32'sd1073741824 && quat_z_reg >= -32'sd1073741824
                          && quat_w_reg <= 32'sd1073741824 && quat_w_reg >= -32'sd1073741824))
        else $error("quaternion component outside clamp range");
`endif

endmodule

### rtl/core/yri_front.sv
`timescale 1ns / 1ps

module yri_front
    import yri_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [STAMP_W-1:0]   stamp_ns,
    input  logic [RATE_W-1:0]    yaw_rate,
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 chain_adv,
    output front_t               front
);

    fe_state_t              state_reg, state_next;
    logic [DEADBAND_W-1:0]  deadband_reg;
    logic [FIXED_W-1:0]     fixed_reg;
    logic [ANGLE_W-1:0]     yaw_reg, yaw_next;
    logic [STAMP_W-1:0]     prev_reg;
    logic [STAMP_W-1:0]     stamp_reg;
    logic [RATE_W-1:0]      rmag_reg;
    logic                   rneg_reg;
    logic [STEP_W-1:0]      dmag_reg;
    logic                   neg_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [31:0]            lo_reg;
    logic [47:0]            hi_reg;

    logic                   accept;
    logic                   front_valid;
    logic [STAMP_W:0]       fwd;
    logic [STAMP_W-1:0]     back;
    logic                   fwd_ge;
    logic [STAMP_W-1:0]     diff;
    logic [STEP_W-1:0]      dsat;
    logic [STEP_W-1:0]      dmag;
    logic                   dneg;
    logic                   above_band;
    logic [31:0]            mul_a, mul_b;
    logic [63:0]            mul_p;
    logic [47:0]            mid;
    logic [ANGLE_W-1:0]     inc;

    assign accept = in_valid && in_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FE_IDLE: if (in_valid) state_next = FE_STEP;
            FE_STEP: state_next = FE_MUL;
            FE_MUL:  state_next = FE_LO;
            FE_LO:   state_next = FE_HI;
            FE_HI:   state_next = FE_ADD;
            FE_ADD:  if (chain_adv) state_next = FE_IDLE;
            default: state_next = FE_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready    = 1'b0;
        front_valid = 1'b0;
        case (state_reg)
            FE_IDLE: in_ready    = 1'b1;
            FE_ADD:  front_valid = 1'b1;
            default:
            begin
                in_ready    = 1'b0;
                front_valid = 1'b0;
            end
        endcase
    end

    assign front = '{valid: front_valid, yaw: yaw_next};

    // time step: stamp difference saturated at 2^31 ns either way, or the fixed step
    always_comb
    begin
        fwd    = {1'b0, stamp_reg} - {1'b0, prev_reg};
        back   = prev_reg - stamp_reg;
        fwd_ge = !fwd[STAMP_W];
        diff   = fwd_ge ? fwd[STAMP_W-1:0] : back;
        if ((|diff[STAMP_W-1:32]) || (diff[31] && (|diff[30:0])))
            dsat = STEP_LIMIT;
        else
            dsat = diff[STEP_W-1:0];
        dmag = '0;
        dneg = 1'b0;
        if (prev_reg >= ONE_SECOND_NS)
        begin
            dmag = dsat;
            dneg = !fwd_ge;
        end
        if (fixed_reg > MIN_FIXED_STEP_NS)
        begin
            dmag = {{(STEP_W-FIXED_W){1'b0}}, fixed_reg};
            dneg = 1'b0;
        end
        above_band = rmag_reg > {1'b0, deadband_reg};
    end

    // one shared multiplier: rate * step, then the product times the angle scale in two halves
    always_comb
    begin
        case (state_reg)
            FE_MUL:
            begin
                mul_a = rmag_reg;
                mul_b = dmag_reg;
            end
            FE_HI:
            begin
                mul_a = {1'b0, prod_reg[PROD_W-1:32]};
                mul_b = ANGLE_PER_RATE_NS;
            end
            default:
            begin
                mul_a = prod_reg[31:0];
                mul_b = ANGLE_PER_RATE_NS;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb
    begin
        mid      = hi_reg + {16'd0, lo_reg} + 48'd32768;
        inc      = mid[47:16];
        yaw_next = neg_reg ? (yaw_reg - inc) : (yaw_reg + inc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= FE_IDLE;
            deadband_reg <= '0;
            fixed_reg    <= '0;
            yaw_reg      <= '0;
            prev_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_RATE_DEADBAND: deadband_reg <= cfg_data[DEADBAND_W-1:0];
                    REG_FIXED_STEP:    fixed_reg    <= cfg_data[FIXED_W-1:0];
                    default:           deadband_reg <= deadband_reg;
                endcase
            end
            if (state_reg == FE_STEP)
                prev_reg <= stamp_reg;
            if (state_reg == FE_ADD && chain_adv)
                yaw_reg <= yaw_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stamp_reg <= stamp_ns;
            rneg_reg  <= yaw_rate[RATE_W-1];
            rmag_reg  <= yaw_rate[RATE_W-1] ? (~yaw_rate + 1'b1) : yaw_rate;
        end
        if (state_reg == FE_STEP)
        begin
            dmag_reg <= dmag;
            neg_reg  <= rneg_reg ^ dneg;
            // a rate inside the deadband adds nothing: zero it
            if (!above_band)
                rmag_reg <= '0;
        end
        if (state_reg == FE_MUL)
            prod_reg <= mul_p[PROD_W-1:0];
        if (state_reg == FE_LO)
            lo_reg <= mul_p[63:32];
        if (state_reg == FE_HI)
            hi_reg <= mul_p[47:0];
    end

`ifndef SYNTHESIS
    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("front end took a second item while busy");

    a_yaw_only_on_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg == FE_ADD && chain_adv) |=> $stable(yaw_reg))
        else $error("yaw changed without an item entering the cells");

    a_wait_for_cells: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FE_ADD && !chain_adv) |=> state_reg == FE_ADD)
        else $error("item dropped while the cells were stalled");
`endif

endmodule

### rtl/core/yri_cordic_cell.sv
`timescale 1ns / 1ps

module yri_cordic_cell
    import yri_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic [4:0]        idx,
    input  cell_t             cin,
    output cell_t             cout
);

    logic signed [XY_W-1:0] x_in, y_in, xs, ys;
    logic signed [Z_W-1:0]  z_in, ang;
    cell_t                  res;
    logic                   valid_reg;
    logic [XY_W-1:0]        x_reg;
    logic [XY_W-1:0]        y_reg;
    logic [Z_W-1:0]         z_reg;
    logic [ANGLE_W-1:0]     yaw_reg;

    always_comb
    begin
        x_in = $signed(cin.x);
        y_in = $signed(cin.y);
        z_in = $signed(cin.z);
        xs   = x_in >>> idx;
        ys   = y_in >>> idx;
        ang  = $signed({{(Z_W-31){1'b0}}, atan_q(idx)});
        res  = cin;
        if (!z_in[Z_W-1])
        begin
            res.x = x_in - ys;
            res.y = y_in + xs;
            res.z = z_in - ang;
        end
        else
        begin
            res.x = x_in + ys;
            res.y = y_in - xs;
            res.z = z_in + ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= cin.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg   <= res.x;
            y_reg   <= res.y;
            z_reg   <= res.z;
            yaw_reg <= res.yaw;
        end
    end

    assign cout = '{valid: valid_reg, x: x_reg, y: y_reg, z: z_reg, yaw: yaw_reg};

endmodule
